// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

  localparam int unsigned DIV_W = 32;

  localparam logic [31:0] B6_OFS  = 32'd4000;
  localparam logic [31:0] P_C1    = 32'd3038;
  localparam logic [31:0] P_C2    = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3    = 32'd3791;
  localparam logic [31:0] B7_BASE = 32'd50000;
  localparam logic [31:0] B7_TOP  = 32'h8000_0000;
  localparam logic [31:0] X3_OFS  = 32'd32768;

  typedef enum logic [2:0] {
    CFG_AC1     = 3'd0,
    CFG_AC2     = 3'd1,
    CFG_AC3     = 3'd2,
    CFG_AC4     = 3'd3,
    CFG_AC5_AC6 = 3'd4,
    CFG_B1_B2   = 3'd5,
    CFG_MC_MD   = 3'd6,
    CFG_OSS     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        op;
    logic [15:0] ut;
    logic [18:0] up;
  } item_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } q_status_t;

endpackage

// ----- rtl/bpc_front.sv -----
module bpc_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpc_pkg::item_t    in_item_i,
  input  logic              pop_i,
  output bpc_pkg::item_t    item_o,
  output bpc_pkg::q_status_t status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bpc_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic push, pop;
  bpc_pkg::item_t norm;

  // op only ever carries one bit, nothing else to classify beyond the tag
  always_comb begin
    norm    = in_item_i;
    norm.op = in_item_i.op;
  end

  assign in_ready_o        = (cnt_q != CW'(DEPTH));
  assign push              = in_valid_i && in_ready_o;
  assign pop               = pop_i && (cnt_q != '0);
  assign status_o.nonempty = (cnt_q != '0);
  assign status_o.full     = (cnt_q == CW'(DEPTH));
  assign item_o            = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= norm;
    end
  end

endmodule

// ----- rtl/bpc_div.sv -----
module bpc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quot_o,
  output logic [SW-1:0] side_o
);

  logic [W-1:0]  rem_q  [W];
  logic [W-1:0]  dq_q   [W];
  logic [W-1:0]  dvs_q  [W];
  logic [SW-1:0] side_q [W];
  logic [W-1:0]  vld_q;

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W-1:0]  rem_in, dq_in, dvs_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [W:0]    t, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = dividend_i;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = vld_q[s-1];
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign t    = {rem_in, dq_in[W-1]};
    assign diff = t - {1'b0, dvs_in};
    assign ge   = (t >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[W-1:0] : t[W-1:0];
        dq_q[s]   <= {dq_in[W-2:0], ge};
        dvs_q[s]  <= dvs_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[W-1];
  assign quot_o  = dq_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// ----- rtl/bpc_engine.sv -----
module bpc_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bpc_pkg::cal_t  cal_i,
  input  logic           item_valid_i,
  input  bpc_pkg::item_t item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [31:0]    value_o,
  output logic           kind_o,
  output logic           error_o
);

  typedef struct packed {
    logic        op;
    logic [18:0] up;
    logic [31:0] x1;
    logic        neg;
    logic        zero;
  } d1_side_t;

  typedef struct packed {
    logic        op;
    logic        err;
    logic [31:0] tval;
    logic        big;
    logic        zero;
  } d2_side_t;

  localparam int unsigned S1W = $bits(d1_side_t);
  localparam int unsigned S2W = $bits(d2_side_t);

  logic en;
  logic out_valid_q;
  logic [31:0] value_q;
  logic kind_q, error_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && item_valid_i;

  // stage valids
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v8_q, v9_q, v10_q;

  // s0: temperature product
  logic        s0_op_q;
  logic [18:0] s0_up_q;
  logic signed [33:0] s0_prod_q;
  logic signed [16:0] ut_d;
  assign ut_d = $signed({1'b0, item_i.ut}) - $signed({1'b0, cal_i.ac6});

  // s1: divider operands
  logic signed [33:0] x1_sh;
  logic [31:0] x1_w, den, num;
  assign x1_sh = s0_prod_q >>> 15;
  assign x1_w  = x1_sh[31:0];
  assign den   = x1_w + {{16{cal_i.md[15]}}, cal_i.md};
  assign num   = {{5{cal_i.mc[15]}}, cal_i.mc, 11'b0};
  d1_side_t    s1_side_q;
  logic [31:0] s1_num_q, s1_den_q;

  // first divider
  logic        d1_valid;
  logic [31:0] d1_quot;
  logic [S1W-1:0] d1_side_raw;
  d1_side_t    d1_side;
  assign d1_side = d1_side_t'(d1_side_raw);

  bpc_div #(.W(bpc_pkg::DIV_W), .SW(S1W)) u_div_t (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v1_q),
    .dividend_i(s1_num_q),
    .divisor_i (s1_den_q),
    .side_i    (S1W'(s1_side_q)),
    .valid_o   (d1_valid),
    .quot_o    (d1_quot),
    .side_o    (d1_side_raw)
  );

  // s2: b5
  logic [31:0] x2_t;
  assign x2_t = d1_side.neg ? (32'd0 - d1_quot) : d1_quot;
  logic        s2_op_q, s2_err_q;
  logic [18:0] s2_up_q;
  logic [31:0] s2_b5_q;

  // s3: b6 products
  logic [31:0] b6, b5r;
  assign b6  = s2_b5_q - bpc_pkg::B6_OFS;
  assign b5r = s2_b5_q + 32'd8;
  logic        s3_op_q, s3_err_q;
  logic [18:0] s3_up_q;
  logic [31:0] s3_tval_q, s3_m66_q, s3_ma2_q, s3_ma3_q;

  // s4
  logic [31:0] sq;
  assign sq = 32'($signed(s3_m66_q) >>> 12);
  logic        s4_op_q, s4_err_q;
  logic [18:0] s4_up_q;
  logic [31:0] s4_tval_q, s4_mb1_q, s4_mb2_q, s4_x2a_q, s4_x1c_q;

  // s5: b3 and b4 operand
  logic [31:0] x1_b, x3_a, b3_pre, x2_b, x3_b;
  assign x1_b   = 32'($signed(s4_mb2_q) >>> 11);
  assign x3_a   = x1_b + s4_x2a_q;
  assign b3_pre = (({{16{cal_i.ac1[15]}}, cal_i.ac1} << 2) + x3_a) << cal_i.oss;
  assign x2_b   = 32'($signed(s4_mb1_q) >>> 16);
  assign x3_b   = 32'($signed(s4_x1c_q + x2_b + 32'd2) >>> 2);
  logic        s5_op_q, s5_err_q;
  logic [18:0] s5_up_q;
  logic [31:0] s5_tval_q, s5_b3_q, s5_t_q;

  // s6
  logic        s6_op_q, s6_err_q;
  logic [31:0] s6_tval_q, s6_mb4_q, s6_b7_q;

  // second divider operands
  logic [31:0] b4;
  assign b4 = s6_mb4_q >> 15;

  logic        d2_valid;
  logic [31:0] d2_quot;
  logic [S2W-1:0] d2_side_raw;
  d2_side_t    d2_in, d2_side;
  assign d2_side = d2_side_t'(d2_side_raw);
  always_comb begin
    d2_in.op   = s6_op_q;
    d2_in.err  = s6_err_q;
    d2_in.tval = s6_tval_q;
    d2_in.big  = (s6_b7_q >= bpc_pkg::B7_TOP);
    d2_in.zero = (b4 == '0);
  end

  bpc_div #(.W(bpc_pkg::DIV_W), .SW(S2W)) u_div_p (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v6_q),
    .dividend_i(d2_in.big ? s6_b7_q : {s6_b7_q[30:0], 1'b0}),
    .divisor_i (b4),
    .side_i    (S2W'(d2_in)),
    .valid_o   (d2_valid),
    .quot_o    (d2_quot),
    .side_o    (d2_side_raw)
  );

  // s8..s10: final correction
  logic        s8_op_q, s8_err_q;
  logic [31:0] s8_tval_q, s8_p_q;
  logic [31:0] xs;
  assign xs = 32'($signed(s8_p_q) >>> 8);
  logic        s9_op_q, s9_err_q;
  logic [31:0] s9_tval_q, s9_p_q, s9_m1_q, s9_mp_q;
  logic        s10_op_q, s10_err_q;
  logic [31:0] s10_tval_q, s10_p_q, s10_m2_q, s10_mp_q;

  logic [31:0] fx1, fx2, pres;
  assign fx1  = 32'($signed(s10_m2_q) >>> 16);
  assign fx2  = 32'($signed(s10_mp_q) >>> 16);
  assign pres = s10_p_q + 32'($signed(fx1 + fx2 + bpc_pkg::P_C3) >>> 4);

  // v6_q is also the valid into the second divider, v8_q follows its output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
      v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v0_q  <= item_valid_i;
        v1_q  <= v0_q;
        v2_q  <= d1_valid;
        v3_q  <= v2_q;
        v4_q  <= v3_q;
        v5_q  <= v4_q;
        v6_q  <= v5_q;
        v8_q  <= d2_valid;
        v9_q  <= v8_q;
        v10_q <= v9_q;
        out_valid_q <= v10_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q   <= item_i.op;
      s0_up_q   <= item_i.up;
      s0_prod_q <= 34'(ut_d * $signed({1'b0, cal_i.ac5}));

      s1_side_q.op   <= s0_op_q;
      s1_side_q.up   <= s0_up_q;
      s1_side_q.x1   <= x1_w;
      s1_side_q.neg  <= num[31] ^ den[31];
      s1_side_q.zero <= (den == '0);
      s1_num_q <= num[31] ? (32'd0 - num) : num;
      s1_den_q <= den[31] ? (32'd0 - den) : den;

      s2_op_q  <= d1_side.op;
      s2_err_q <= d1_side.zero;
      s2_up_q  <= d1_side.up;
      s2_b5_q  <= d1_side.x1 + x2_t;

      s3_op_q   <= s2_op_q;
      s3_err_q  <= s2_err_q;
      s3_up_q   <= s2_up_q;
      s3_tval_q <= 32'($signed(b5r) >>> 4);
      s3_m66_q  <= 32'(b6 * b6);
      s3_ma2_q  <= 32'({{16{cal_i.ac2[15]}}, cal_i.ac2} * b6);
      s3_ma3_q  <= 32'({{16{cal_i.ac3[15]}}, cal_i.ac3} * b6);

      s4_op_q   <= s3_op_q;
      s4_err_q  <= s3_err_q;
      s4_up_q   <= s3_up_q;
      s4_tval_q <= s3_tval_q;
      s4_mb2_q  <= 32'({{16{cal_i.b2[15]}}, cal_i.b2} * sq);
      s4_mb1_q  <= 32'({{16{cal_i.b1[15]}}, cal_i.b1} * sq);
      s4_x2a_q  <= 32'($signed(s3_ma2_q) >>> 11);
      s4_x1c_q  <= 32'($signed(s3_ma3_q) >>> 13);

      s5_op_q   <= s4_op_q;
      s5_err_q  <= s4_err_q;
      s5_up_q   <= s4_up_q;
      s5_tval_q <= s4_tval_q;
      s5_b3_q   <= 32'($signed(b3_pre + 32'd2) >>> 2);
      s5_t_q    <= x3_b + bpc_pkg::X3_OFS;

      s6_op_q   <= s5_op_q;
      s6_err_q  <= s5_err_q;
      s6_tval_q <= s5_tval_q;
      s6_mb4_q  <= 32'({16'd0, cal_i.ac4} * s5_t_q);
      s6_b7_q   <= 32'(({13'd0, s5_up_q} - s5_b3_q) * (bpc_pkg::B7_BASE >> cal_i.oss));

      s8_op_q   <= d2_side.op;
      s8_err_q  <= d2_side.err | (d2_side.op & d2_side.zero);
      s8_tval_q <= d2_side.tval;
      s8_p_q    <= d2_side.big ? {d2_quot[30:0], 1'b0} : d2_quot;

      s9_op_q   <= s8_op_q;
      s9_err_q  <= s8_err_q;
      s9_tval_q <= s8_tval_q;
      s9_p_q    <= s8_p_q;
      s9_m1_q   <= 32'(xs * xs);
      s9_mp_q   <= 32'(bpc_pkg::P_C2 * s8_p_q);

      s10_op_q   <= s9_op_q;
      s10_err_q  <= s9_err_q;
      s10_tval_q <= s9_tval_q;
      s10_p_q    <= s9_p_q;
      s10_m2_q   <= 32'(s9_m1_q * bpc_pkg::P_C1);
      s10_mp_q   <= s9_mp_q;

      kind_q  <= s10_op_q;
      error_q <= s10_err_q;
      value_q <= s10_err_q ? '0 : (s10_op_q ? pres : s10_tval_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign kind_o      = kind_q;
  assign error_o     = error_q;

endmodule

// ----- rtl/barometer_temp_pressure_compensation_top.sv -----
// Integer compensation for a barometric sensor. Write the calibration words and
// the oversampling setting through the cfg port while the block is idle, then
// stream items of op, raw temperature and pre-shifted raw pressure. Each item
// gives one result: temperature in 0.1 degC or pressure in Pa, with an error flag
// and a zero value when a divisor was zero. One item is taken every cycle while
// the pipeline is not stalled; results pass through the two 32-stage pipelined
// dividers (temperature term and pressure quotient) and the multiply stages
// around them. A short input queue decouples intake from the compute
// pipeline, which stalls as a whole while the output register waits.
module barometer_temp_pressure_compensation_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // raw_temp[15:0], raw_pressure[34:16], zero pad
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // value
  output logic [1:0]  m_axis_tuser,  // kind[0], error[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  bpc_pkg::cal_t      cal_q;
  bpc_pkg::item_t     in_item, q_item;
  bpc_pkg::q_status_t q_status;
  logic               eng_pop;
  logic               kind, error;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_index_i))
        bpc_pkg::CFG_AC1: cal_q.ac1 <= cfg_data_i[15:0];
        bpc_pkg::CFG_AC2: cal_q.ac2 <= cfg_data_i[15:0];
        bpc_pkg::CFG_AC3: cal_q.ac3 <= cfg_data_i[15:0];
        bpc_pkg::CFG_AC4: cal_q.ac4 <= cfg_data_i[15:0];
        bpc_pkg::CFG_AC5_AC6: begin
          cal_q.ac5 <= cfg_data_i[31:16];
          cal_q.ac6 <= cfg_data_i[15:0];
        end
        bpc_pkg::CFG_B1_B2: begin
          cal_q.b1 <= cfg_data_i[31:16];
          cal_q.b2 <= cfg_data_i[15:0];
        end
        bpc_pkg::CFG_MC_MD: begin
          cal_q.mc <= cfg_data_i[31:16];
          cal_q.md <= cfg_data_i[15:0];
        end
        bpc_pkg::CFG_OSS: cal_q.oss <= cfg_data_i[1:0];
        default: cal_q <= cal_q;
      endcase
    end
  end

  always_comb begin
    in_item.op = s_axis_tuser;
    in_item.ut = s_axis_tdata[15:0];
    in_item.up = s_axis_tdata[34:16];
  end

  bpc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .pop_i     (eng_pop),
    .item_o    (q_item),
    .status_o  (q_status)
  );

  bpc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal_q),
    .item_valid_i(q_status.nonempty),
    .item_i      (q_item),
    .pop_o       (eng_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (m_axis_tdata),
    .kind_o      (kind),
    .error_o     (error)
  );

  assign m_axis_tuser = {error, kind};

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
    else $error("error result with nonzero value");

  a_full_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> q_status.nonempty && !s_axis_tready)
    else $error("queue full but intake open");

  a_stall_nopop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !eng_pop)
    else $error("queue drained while output stalled");

endmodule

// ----- sim/tb_barometer_temp_pressure_compensation_top.sv -----
module tb_barometer_temp_pressure_compensation_top;

  typedef struct {
    logic [31:0] value;
    logic        kind;
    logic        error;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  barometer_temp_pressure_compensation_top dut (.*);

  // calibration copy held by the predictor
  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [1:0]  oss;

  reading_t    pending_readings[$];
  int          src_idle_pct, snk_idle_pct;
  int          errors, n_sent, n_got, n_temp, n_press, n_div0, idle_cycles;
  bit          sink_hold;
  bit          timed_out;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] asr(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic reading_t compensate(input logic op, input logic [15:0] ut,
                                          input logic [18:0] up);
    reading_t r;
    longint prod;
    logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, c_ac1, c_ac2, c_ac3;
    logic [31:0] c_b1, c_b2;
    int q;
    r.kind = op;
    r.error = 0;
    r.value = 0;
    prod = (longint'(ut) - longint'(ac6)) * longint'(ac5);
    x1 = 32'(prod >>> 15);
    den = x1 + 32'($signed(md));
    if (den == 0) begin
      r.error = 1;
      return r;
    end
    q = ($signed(mc) * 2048) / $signed(den);
    b5 = x1 + 32'(q);
    if (!op) begin
      r.value = asr(b5 + 8, 4);
      return r;
    end
    c_ac1 = 32'($signed(ac1));
    c_ac2 = 32'($signed(ac2));
    c_ac3 = 32'($signed(ac3));
    c_b1 = 32'($signed(b1));
    c_b2 = 32'($signed(b2));
    b6 = b5 - bpc_pkg::B6_OFS;
    sq = asr(b6 * b6, 12);
    x1 = asr(c_b2 * sq, 11);
    x2 = asr(c_ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = asr(((c_ac1 * 4 + x3) << oss) + 2, 2);
    x1 = asr(c_ac3 * b6, 13);
    x2 = asr(c_b1 * sq, 16);
    x3 = asr(x1 + x2 + 2, 2);
    b4 = ({16'd0, ac4} * (x3 + bpc_pkg::X3_OFS)) >> 15;
    if (b4 == 0) begin
      r.error = 1;
      return r;
    end
    b7 = ({13'd0, up} - b3) * (bpc_pkg::B7_BASE >> oss);
    if (b7 < bpc_pkg::B7_TOP) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = asr(p, 8);
    x1 = x1 * x1;
    x1 = asr(x1 * bpc_pkg::P_C1, 16);
    x2 = asr(bpc_pkg::P_C2 * p, 16);
    r.value = p + asr(x1 + x2 + bpc_pkg::P_C3, 4);
    return r;
  endfunction

  task automatic write_reg(input bpc_pkg::cfg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
    case (idx)
      bpc_pkg::CFG_AC1:     ac1 = data[15:0];
      bpc_pkg::CFG_AC2:     ac2 = data[15:0];
      bpc_pkg::CFG_AC3:     ac3 = data[15:0];
      bpc_pkg::CFG_AC4:     ac4 = data[15:0];
      bpc_pkg::CFG_AC5_AC6: {ac5, ac6} = data;
      bpc_pkg::CFG_B1_B2:   {b1, b2} = data;
      bpc_pkg::CFG_MC_MD:   {mc, md} = data;
      bpc_pkg::CFG_OSS:     oss = data[1:0];
    endcase
  endtask

  task automatic send_sample(input logic op, input logic [15:0] ut, input logic [18:0] up);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'd0, up, ut};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(compensate(op, ut, up));
    n_sent++;
    if (op) n_press++;
    else n_temp++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // typical sensor datasheet calibration
  task automatic load_typical();
    write_reg(bpc_pkg::CFG_AC1, 32'd408);
    write_reg(bpc_pkg::CFG_AC2, 32'hFFFF_FFCA);
    write_reg(bpc_pkg::CFG_AC3, 32'hFFFF_C6C4);
    write_reg(bpc_pkg::CFG_AC4, 32'd32741);
    write_reg(bpc_pkg::CFG_AC5_AC6, {16'd32757, 16'd23153});
    write_reg(bpc_pkg::CFG_B1_B2, {16'd6190, 16'd4});
    write_reg(bpc_pkg::CFG_MC_MD, {16'hD4BD, 16'd2868});
    write_reg(bpc_pkg::CFG_OSS, 32'd0);
  endtask

  task automatic test_directed();
    load_typical();
    send_sample(0, 16'd27898, 19'd0);
    send_sample(1, 16'd27898, 19'd23843);
    send_sample(0, 16'h0000, 19'h7FFFF);
    send_sample(1, 16'hFFFF, 19'h7FFFF);
    send_sample(1, 16'h0000, 19'h00000);
    send_sample(1, 16'h5555, 19'h2AAAA);
    send_sample(0, 16'hAAAA, 19'h55555);
    drain();
    // zero temperature divisor: ac5 = 0 makes x1 = 0, md = 0
    write_reg(bpc_pkg::CFG_AC5_AC6, 32'h0000_FFFF);
    write_reg(bpc_pkg::CFG_MC_MD, 32'h8000_0000);
    send_sample(0, 16'd1234, 19'd5);
    send_sample(1, 16'd1234, 19'd5);
    drain();
    // zero pressure divisor: ac4 = 0
    write_reg(bpc_pkg::CFG_MC_MD, 32'h7FFF_0001);
    write_reg(bpc_pkg::CFG_AC4, 32'd0);
    send_sample(1, 16'd100, 19'd300);
    send_sample(0, 16'd100, 19'd300);
    drain();
    // extremes of the calibration words, oversampling at max
    write_reg(bpc_pkg::CFG_AC1, 32'h8000);
    write_reg(bpc_pkg::CFG_AC2, 32'h7FFF);
    write_reg(bpc_pkg::CFG_AC3, 32'h8000);
    write_reg(bpc_pkg::CFG_AC4, 32'hFFFF);
    write_reg(bpc_pkg::CFG_AC5_AC6, 32'hFFFF_0000);
    write_reg(bpc_pkg::CFG_B1_B2, 32'h7FFF_8000);
    write_reg(bpc_pkg::CFG_MC_MD, 32'h8000_7FFF);
    write_reg(bpc_pkg::CFG_OSS, 32'd3);
    for (int i = 0; i < 6; i++)
      send_sample(i[0], i[1] ? 16'hFFFF : 16'h0000, i[2] ? 19'h7FFFF : 19'h0);
    drain();
  endtask

  task automatic test_random(input int count, input bit random_cal);
    if (random_cal) begin
      write_reg(bpc_pkg::CFG_AC1, $urandom);
      write_reg(bpc_pkg::CFG_AC2, $urandom);
      write_reg(bpc_pkg::CFG_AC3, $urandom);
      write_reg(bpc_pkg::CFG_AC4, $urandom);
      write_reg(bpc_pkg::CFG_AC5_AC6, $urandom);
      write_reg(bpc_pkg::CFG_B1_B2, $urandom);
      write_reg(bpc_pkg::CFG_MC_MD, $urandom);
    end else begin
      load_typical();
    end
    write_reg(bpc_pkg::CFG_OSS, $urandom_range(3));
    for (int i = 0; i < count; i++) begin
      // mostly realistic raw words near the typical range, some fully random
      if ($urandom_range(3) != 0)
        send_sample(1'($urandom_range(1)), 16'($urandom_range(33000, 22000)),
                    19'($urandom_range(45000, 8000) << oss));
      else
        send_sample(1'($urandom_range(1)), 16'($urandom), 19'($urandom));
    end
    drain();
  endtask

  // more items than the pipeline and queue hold, so intake must stall
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_hold = 1;
    for (int i = 0; i < 100; i++)
      send_sample(1'($urandom_range(1)), 16'($urandom), 19'($urandom));
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off while sink_hold is set
  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
        sink_hold = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      @(posedge clk_i);
    end
  end

  // compare each transfer on the result side with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_got++;
      if (m_axis_tuser[1]) n_div0++;
      if (pending_readings.size() == 0) begin
        $display("%0t unexpected result value=%h kind=%b error=%b", $time,
                 m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        errors++;
      end else begin
        reading_t e;
        e = pending_readings.pop_front();
        if (e.value !== m_axis_tdata) begin
          $display("%0t value mismatch expected %h actual %h", $time, e.value, m_axis_tdata);
          errors++;
        end
        if (e.kind !== m_axis_tuser[0]) begin
          $display("%0t kind mismatch expected %b actual %b", $time, e.kind, m_axis_tuser[0]);
          errors++;
        end
        if (e.error !== m_axis_tuser[1]) begin
          $display("%0t error mismatch expected %b actual %b", $time, e.error,
                   m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    errors = 0; n_sent = 0; n_got = 0; n_temp = 0; n_press = 0; n_div0 = 0;
    idle_cycles = 0; sink_hold = 0; timed_out = 0;
    {ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, oss} = '0;
    rst_ni = 0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
    cfg_valid_i = 0; cfg_index_i = bpc_pkg::CFG_AC1; cfg_data_i = '0;
    src_idle_pct = 0; snk_idle_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    src_idle_pct = 17; snk_idle_pct = 67;
    test_random(140, 0);
    test_random(140, 1);
    src_idle_pct = 67; snk_idle_pct = 17;
    test_random(140, 0);
    test_random(140, 1);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random(140, 0);
    test_random(140, 1);
    test_backpressure();
    repeat (100) @(posedge clk_i);
    $display("sent %0d samples (%0d temperature, %0d pressure), checked %0d results",
             n_sent, n_temp, n_press, n_got);
    $display("zero-divisor results seen: %0d, calibration sets incl. extremes", n_div0);
    if (errors == 0 && pending_readings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
